// ----- rtl/core/i2crts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - shared definitions
// Beat types, bus command and phase codes, and bus status codes.
// ----------------------------------------------------------------------------
package i2crts_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_REG = 2'd0,
        OP_READ_REG  = 2'd1,
        OP_BUS_DONE  = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_SEND      = 3'd2,
        CMD_RECV_ACK  = 3'd3,
        CMD_RECV_NACK = 3'd4,
        CMD_STOP      = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START1 = 4'd1,
        PH_ADDR_W = 4'd2,
        PH_REG    = 4'd3,
        PH_VAL    = 4'd4,
        PH_RSTART = 4'd5,
        PH_ADDR_R = 4'd6,
        PH_RECV   = 4'd7,
        PH_STOP   = 4'd8
    } phase_t;

    localparam logic [7:0] STATUS_MASK  = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] read_count;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] send_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       finished;
        logic       succeeded;
    } rsp_t;

endpackage

// ----- rtl/core/i2crts_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - transaction state machine
// Holds the transaction context and computes the next bus command per beat.
// ----------------------------------------------------------------------------
module i2crts_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  i2crts_pkg::req_t  item,
    output i2crts_pkg::rsp_t  result
);

    i2crts_pkg::phase_t phase_reg, phase_next;
    logic       is_read_reg, is_read_next;
    logic [6:0] device_reg, device_next;
    logic [7:0] register_reg, register_next;
    logic [7:0] value_reg, value_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       pending_reg, pending_next;

    logic [7:0] status;
    logic       start_ok;
    logic       addr_ok;
    logic       data_ok;
    logic [7:0] bytes_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2crts_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            device_reg     <= 7'd0;
            register_reg   <= 8'd0;
            value_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            pending_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            device_reg     <= device_next;
            register_reg   <= register_next;
            value_reg      <= value_next;
            bytes_left_reg <= bytes_left_next;
            pending_reg    <= pending_next;
        end
    end

    assign status    = item.bus_status & i2crts_pkg::STATUS_MASK;
    assign start_ok  = (status == i2crts_pkg::ST_START) || (status == i2crts_pkg::ST_REP_START);
    assign addr_ok   = (status == i2crts_pkg::ST_SLA_W_ACK) || (status == i2crts_pkg::ST_SLA_R_ACK);
    assign data_ok   = (status == i2crts_pkg::ST_DATA_ACK);
    assign bytes_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        device_next     = device_reg;
        register_next   = register_reg;
        value_next      = value_reg;
        bytes_left_next = bytes_left_reg;
        pending_next    = pending_reg;
        result          = '0;

        if (((item.op == i2crts_pkg::OP_WRITE_REG) || (item.op == i2crts_pkg::OP_READ_REG))
            && (phase_reg == i2crts_pkg::PH_IDLE))
        begin
            is_read_next       = (item.op == i2crts_pkg::OP_READ_REG);
            device_next        = item.device_address;
            register_next      = item.register_address;
            value_next         = item.write_value;
            bytes_left_next    = (item.op == i2crts_pkg::OP_READ_REG) ? item.read_count : 8'd0;
            pending_next       = 1'b0;
            result.bus_command = i2crts_pkg::CMD_START;
            phase_next         = i2crts_pkg::PH_START1;
        end
        else if (item.op == i2crts_pkg::OP_BUS_DONE)
        begin
            case (phase_reg)
                i2crts_pkg::PH_START1,
                i2crts_pkg::PH_RSTART:
                begin
                    if (!start_ok)
                    begin
                        result.finished = 1'b1;
                        phase_next      = i2crts_pkg::PH_IDLE;
                    end
                    else if (phase_reg == i2crts_pkg::PH_START1)
                    begin
                        result.bus_command = i2crts_pkg::CMD_SEND;
                        result.send_byte   = {device_reg, 1'b0};
                        phase_next         = i2crts_pkg::PH_ADDR_W;
                    end
                    else
                    begin
                        result.bus_command = i2crts_pkg::CMD_SEND;
                        result.send_byte   = {device_reg, 1'b1};
                        phase_next         = i2crts_pkg::PH_ADDR_R;
                    end
                end
                i2crts_pkg::PH_ADDR_W:
                begin
                    if (!addr_ok)
                    begin
                        result.finished = 1'b1;
                        phase_next      = i2crts_pkg::PH_IDLE;
                    end
                    else
                    begin
                        result.bus_command = i2crts_pkg::CMD_SEND;
                        result.send_byte   = register_reg;
                        phase_next         = i2crts_pkg::PH_REG;
                    end
                end
                i2crts_pkg::PH_REG:
                begin
                    if (!data_ok)
                    begin
                        result.bus_command = i2crts_pkg::CMD_STOP;
                        pending_next       = 1'b0;
                        phase_next         = i2crts_pkg::PH_STOP;
                    end
                    else if (is_read_reg)
                    begin
                        result.bus_command = i2crts_pkg::CMD_START;
                        phase_next         = i2crts_pkg::PH_RSTART;
                    end
                    else
                    begin
                        result.bus_command = i2crts_pkg::CMD_SEND;
                        result.send_byte   = value_reg;
                        phase_next         = i2crts_pkg::PH_VAL;
                    end
                end
                i2crts_pkg::PH_VAL:
                begin
                    result.bus_command = i2crts_pkg::CMD_STOP;
                    pending_next       = data_ok;
                    phase_next         = i2crts_pkg::PH_STOP;
                end
                i2crts_pkg::PH_ADDR_R:
                begin
                    if (!addr_ok)
                    begin
                        result.finished = 1'b1;
                        phase_next      = i2crts_pkg::PH_IDLE;
                    end
                    else if (bytes_left_reg == 8'd0)
                    begin
                        result.bus_command = i2crts_pkg::CMD_STOP;
                        pending_next       = 1'b1;
                        phase_next         = i2crts_pkg::PH_STOP;
                    end
                    else
                    begin
                        result.bus_command = (bytes_left_reg == 8'd1) ? i2crts_pkg::CMD_RECV_NACK
                                                                      : i2crts_pkg::CMD_RECV_ACK;
                        phase_next         = i2crts_pkg::PH_RECV;
                    end
                end
                i2crts_pkg::PH_RECV:
                begin
                    result.read_data  = item.received_byte;
                    result.read_valid = 1'b1;
                    bytes_left_next   = bytes_dec;
                    if (bytes_dec == 8'd0)
                    begin
                        result.bus_command = i2crts_pkg::CMD_STOP;
                        pending_next       = 1'b1;
                        phase_next         = i2crts_pkg::PH_STOP;
                    end
                    else
                    begin
                        result.bus_command = (bytes_dec == 8'd1) ? i2crts_pkg::CMD_RECV_NACK
                                                                 : i2crts_pkg::CMD_RECV_ACK;
                    end
                end
                i2crts_pkg::PH_STOP:
                begin
                    result.finished  = 1'b1;
                    result.succeeded = pending_reg;
                    phase_next       = i2crts_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = i2crts_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/i2c_register_transaction_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - top level
// Turns register read/write requests and bus completion beats into I2C
// master bus commands, received bytes and transaction outcomes.
//
// Channels: req carries one request or bus completion per beat (req_valid,
// req_stall); rsp carries exactly one result beat per request beat
// (rsp_valid, rsp_stall).
// Path: an accepted request beat lands in the input register; its result
// is loaded into the output register when the output register is free or
// rsp_stall is low, and rsp_valid rises with it.
// Throughput: one beat per cycle while rsp_stall is low; the state update
// is a single short step between the input register and the output register.
// Stall: while rsp_stall is high the result beat holds; the input register
// still fills, and req_stall rises only when both registers are full.
// Reset: rst_n low empties both registers and returns the sequencer to idle
// with an empty transaction context.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  i2crts_pkg::req_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output i2crts_pkg::rsp_t  rsp
);

    logic              stage_valid_reg;
    i2crts_pkg::req_t  stage_reg;
    logic              rsp_valid_reg;
    i2crts_pkg::rsp_t  rsp_reg;
    logic              advance;
    i2crts_pkg::rsp_t  result;

    assign advance   = stage_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = stage_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            stage_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    i2crts_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_reg),
        .result  (result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/i2crts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer - port checker
// Watches the result channel for consistent command and outcome beats.
// ----------------------------------------------------------------------------
module i2crts_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input i2crts_pkg::rsp_t  rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_ok_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.succeeded |-> rsp.finished)
        else $error("success flagged without finish");

    a_fin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.finished |->
            rsp.bus_command == i2crts_pkg::CMD_NONE && !rsp.read_valid)
        else $error("finish beat carries a bus command or data");

    a_rx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_valid |->
            rsp.bus_command == i2crts_pkg::CMD_RECV_ACK ||
            rsp.bus_command == i2crts_pkg::CMD_RECV_NACK ||
            rsp.bus_command == i2crts_pkg::CMD_STOP)
        else $error("received byte without receive or stop");

    a_tx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.send_byte != 8'd0 |-> rsp.bus_command == i2crts_pkg::CMD_SEND)
        else $error("send byte set outside send command");

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
